FILE: sv/spw_pkg.sv
// ----------------------------------------------------------------------------
// spw_pkg: shared types, constants and tables
// fixed-point formats, register codes and lookup tables for the wheel speed
// perceptron
// ----------------------------------------------------------------------------
package spw_pkg;

  localparam int DIST_BITS   = 15;
  localparam int NUM_SECTORS = 5;
  localparam int CFG_DATA_W  = 28;
  localparam int CFG_IDX_W   = 3;
  localparam int THR_W       = 12;
  localparam int ACT_W       = 8;   // q0.8 activation, 0..128
  localparam int PROD_W      = 16;  // activation times q4.4 weight
  localparam int SUM_W       = 18;  // wheel sum incl. bias, q.12
  localparam int TIDX_W      = 11;  // tanh index (|s| + 128) >> 8
  localparam int TMAG_W      = 9;   // q0.8 tanh magnitude, 0..256
  localparam int SPEED_W     = 13;
  localparam int MAXSPD_W    = 12;
  localparam int SIG_LEN     = 16;
  localparam int TANH_LEN    = 56;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR4   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd6;

  // reset values
  localparam logic [CFG_DATA_W-1:0] SECTOR_RESET [NUM_SECTORS] = '{
    28'd16843002, 28'd16843252, 28'd16843752, 28'd16843252, 28'd16843002
  };
  localparam logic [7:0]          BIAS_RESET      = 8'd8;
  localparam logic [MAXSPD_W-1:0] MAX_SPEED_RESET = 12'd600;

  localparam logic [TMAG_W-1:0] ONE_Q8 = 9'd256;

  localparam logic [7:0] TANH_TAB [TANH_LEN] = '{
    8'd0,   8'd16,  8'd32,  8'd47,  8'd63,  8'd77,  8'd92,  8'd105,
    8'd118, 8'd131, 8'd142, 8'd153, 8'd163, 8'd172, 8'd180, 8'd188,
    8'd195, 8'd201, 8'd207, 8'd212, 8'd217, 8'd221, 8'd225, 8'd229,
    8'd232, 8'd234, 8'd237, 8'd239, 8'd241, 8'd243, 8'd244, 8'd246,
    8'd247, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd252,
    8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  // one sector register split into its fields
  typedef struct packed {
    logic [7:0]       w_left;
    logic [7:0]       w_right;
    logic [THR_W-1:0] thr;
  } sector_cfg_t;

  // products of one lane for both wheels
  typedef struct packed {
    logic [PROD_W-1:0] p_right;
    logic [PROD_W-1:0] p_left;
  } lane_prod_t;

  // signed tanh result for one wheel
  typedef struct packed {
    logic              neg;
    logic [TMAG_W-1:0] mag;
  } tanh_t;

  // 1/(1+e^d) in q0.8 for d = 0..15
  function automatic logic [ACT_W-1:0] sig_lookup(input logic [3:0] d);
    logic [ACT_W-1:0] a;
    unique case (d)
      4'd0:    a = 8'd128;
      4'd1:    a = 8'd69;
      4'd2:    a = 8'd31;
      4'd3:    a = 8'd12;
      4'd4:    a = 8'd5;
      4'd5:    a = 8'd2;
      4'd6:    a = 8'd1;
      default: a = 8'd0;
    endcase
    return a;
  endfunction

  // tanh magnitude, saturating to one past the table
  function automatic logic [TMAG_W-1:0] tanh_lookup(input logic [TIDX_W-1:0] k);
    logic [TMAG_W-1:0] t;
    if (k >= TIDX_W'(TANH_LEN)) begin
      t = ONE_Q8;
    end else begin
      t = {1'b0, TANH_TAB[k[5:0]]};
    end
    return t;
  endfunction

endpackage

FILE: sv/spw_in_if.sv
// ----------------------------------------------------------------------------
// spw_in_if: distance channel
// valid/ready channel carrying the five sector distances
// ----------------------------------------------------------------------------
interface spw_in_if;
  logic                          valid;
  logic                          ready;
  logic [spw_pkg::DIST_BITS-1:0] dist_0;
  logic [spw_pkg::DIST_BITS-1:0] dist_1;
  logic [spw_pkg::DIST_BITS-1:0] dist_2;
  logic [spw_pkg::DIST_BITS-1:0] dist_3;
  logic [spw_pkg::DIST_BITS-1:0] dist_4;

  modport source (output valid, dist_0, dist_1, dist_2, dist_3, dist_4, input ready);
  modport sink   (input valid, dist_0, dist_1, dist_2, dist_3, dist_4, output ready);
endinterface

FILE: sv/spw_out_if.sv
// ----------------------------------------------------------------------------
// spw_out_if: wheel speed channel
// valid/ready channel carrying the right and left wheel speeds
// ----------------------------------------------------------------------------
interface spw_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [spw_pkg::SPEED_W-1:0] right_speed;
  logic signed [spw_pkg::SPEED_W-1:0] left_speed;

  modport source (output valid, right_speed, left_speed, input ready);
  modport sink   (input valid, right_speed, left_speed, output ready);
endinterface

FILE: sv/spw_lane.sv
// ----------------------------------------------------------------------------
// spw_lane: one sector lane
// thresholded sigmoid activation times the two wheel weights, registered
// ----------------------------------------------------------------------------
module spw_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [spw_pkg::DIST_BITS-1:0] sect_dist,
  input  spw_pkg::sector_cfg_t          scfg,
  output spw_pkg::lane_prod_t           prod
);

  logic [spw_pkg::ACT_W-1:0]    act;
  logic signed [spw_pkg::ACT_W:0] act_s;
  logic signed [16:0]           pr_full;
  logic signed [16:0]           pl_full;
  spw_pkg::lane_prod_t          prod_r;
  spw_pkg::lane_prod_t          prod_nxt;

  always_comb begin
    // beyond the threshold or beyond the table: no activation
    if ((sect_dist > spw_pkg::DIST_BITS'(scfg.thr)) ||
        (sect_dist >= spw_pkg::DIST_BITS'(spw_pkg::SIG_LEN))) begin
      act = '0;
    end else begin
      act = spw_pkg::sig_lookup(sect_dist[3:0]);
    end
    act_s   = signed'({1'b0, act});
    pr_full = act_s * signed'(scfg.w_right);
    pl_full = act_s * signed'(scfg.w_left);
    prod_nxt.p_right = pr_full[spw_pkg::PROD_W-1:0];
    prod_nxt.p_left  = pl_full[spw_pkg::PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

FILE: sv/spw_merge.sv
// ----------------------------------------------------------------------------
// spw_merge: lane merge and tanh
// sums the lane products with the bias per wheel and looks up tanh
// ----------------------------------------------------------------------------
module spw_merge (
  input  logic                clk,
  input  logic                en,
  input  spw_pkg::lane_prod_t prod [spw_pkg::NUM_SECTORS],
  input  logic [7:0]          bias,
  output spw_pkg::tanh_t      th_right,
  output spw_pkg::tanh_t      th_left
);

  logic [spw_pkg::SUM_W-1:0] sum_r;
  logic [spw_pkg::SUM_W-1:0] sum_l;
  spw_pkg::tanh_t            th_right_r;
  spw_pkg::tanh_t            th_left_r;
  spw_pkg::tanh_t            th_right_nxt;
  spw_pkg::tanh_t            th_left_nxt;

  function automatic spw_pkg::tanh_t to_tanh(input logic [spw_pkg::SUM_W-1:0] s);
    spw_pkg::tanh_t              res;
    logic [spw_pkg::SUM_W-1:0]   mag;
    logic [spw_pkg::SUM_W:0]     rnd;
    res.neg = s[spw_pkg::SUM_W-1];
    mag     = res.neg ? (~s + 1'b1) : s;
    // round |s| to the nearest 1/16
    rnd     = {1'b0, mag} + (spw_pkg::SUM_W+1)'(128);
    res.mag = spw_pkg::tanh_lookup(rnd[spw_pkg::SUM_W:8]);
    return res;
  endfunction

  always_comb begin
    sum_r = {{2{bias[7]}}, bias, 8'b0};
    sum_l = sum_r;
    for (int i = 0; i < spw_pkg::NUM_SECTORS; i++) begin
      sum_r = sum_r + {{2{prod[i].p_right[spw_pkg::PROD_W-1]}}, prod[i].p_right};
      sum_l = sum_l + {{2{prod[i].p_left[spw_pkg::PROD_W-1]}}, prod[i].p_left};
    end
    th_right_nxt = to_tanh(sum_r);
    th_left_nxt  = to_tanh(sum_l);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_right_r <= th_right_nxt;
      th_left_r  <= th_left_nxt;
    end
  end

  assign th_right = th_right_r;
  assign th_left  = th_left_r;

endmodule

FILE: sv/spw_scale.sv
// ----------------------------------------------------------------------------
// spw_scale: speed scaling
// tanh times max speed, truncated toward zero, into the output register
// ----------------------------------------------------------------------------
module spw_scale (
  input  logic                                clk,
  input  logic                                en,
  input  spw_pkg::tanh_t                      th,
  input  logic [spw_pkg::MAXSPD_W-1:0]        max_speed,
  output logic signed [spw_pkg::SPEED_W-1:0]  speed
);

  logic [spw_pkg::TMAG_W+spw_pkg::MAXSPD_W-1:0] prod;
  logic [spw_pkg::MAXSPD_W-1:0]                 mag;
  logic signed [spw_pkg::SPEED_W-1:0]           speed_r;
  logic signed [spw_pkg::SPEED_W-1:0]           speed_nxt;

  always_comb begin
    prod = th.mag * max_speed;
    // magnitude never exceeds max speed
    mag  = prod[spw_pkg::MAXSPD_W+7:8];
    speed_nxt = th.neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed_r <= speed_nxt;
    end
  end

  assign speed = speed_r;

endmodule

FILE: sv/sector_perceptron_wheel_speed_top.sv
// ----------------------------------------------------------------------------
// sector_perceptron_wheel_speed_top: laser sector perceptron to wheel speeds
// five sector lanes, a merge stage with tanh and two speed scalers
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one word per scan: the closest distance in mm for five
//   36-degree sectors, dist_0 rightmost to dist_4 leftmost
//   out_ch returns one word per input word: right_speed and left_speed in
//   mm/s, tanh of the weighted sector sum scaled by max_speed
//   cfg_we/cfg_index/cfg_wdata write the five sector words, bias and
//   max_speed; write only while no word is in flight
// timing:
//   latency is 3 cycles from accept to out_ch.valid (lane products, merge
//   and tanh, scale multiply), one register per stage
//   throughput is one word per cycle; the three stages advance together
// stall:
//   when out_ch holds a word that is not taken the whole pipe freezes and
//   in_ch.ready drops; words in flight are held, nothing is lost
// reset:
//   synchronous, active low; clears the pipe valid bits and loads the
//   default thresholds, unit weights, bias 0.5 and max speed 600
// ----------------------------------------------------------------------------
module sector_perceptron_wheel_speed_top (
  input  logic                            clk,
  input  logic                            rst_n,
  spw_in_if.sink                          in_ch,
  spw_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [spw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [spw_pkg::CFG_DATA_W-1:0] sector_word_r [spw_pkg::NUM_SECTORS];
  logic [7:0]                     bias_r;
  logic [spw_pkg::MAXSPD_W-1:0]   max_speed_r;

  // pipe valid bits: lane stage, merge stage, output register
  logic v1_r, v2_r, v3_r;
  logic en;

  logic [spw_pkg::DIST_BITS-1:0] lane_dist [spw_pkg::NUM_SECTORS];
  spw_pkg::lane_prod_t           prod [spw_pkg::NUM_SECTORS];
  spw_pkg::tanh_t                th_right;
  spw_pkg::tanh_t                th_left;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spw_pkg::NUM_SECTORS; i++) begin
        sector_word_r[i] <= spw_pkg::SECTOR_RESET[i];
      end
      bias_r      <= spw_pkg::BIAS_RESET;
      max_speed_r <= spw_pkg::MAX_SPEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spw_pkg::CFG_SECTOR0:   sector_word_r[0] <= cfg_wdata;
        spw_pkg::CFG_SECTOR1:   sector_word_r[1] <= cfg_wdata;
        spw_pkg::CFG_SECTOR2:   sector_word_r[2] <= cfg_wdata;
        spw_pkg::CFG_SECTOR3:   sector_word_r[3] <= cfg_wdata;
        spw_pkg::CFG_SECTOR4:   sector_word_r[4] <= cfg_wdata;
        spw_pkg::CFG_BIAS:      bias_r           <= cfg_wdata[7:0];
        spw_pkg::CFG_MAX_SPEED: max_speed_r      <= cfg_wdata[spw_pkg::MAXSPD_W-1:0];
        default: ;
      endcase
    end
  end

  // the pipe moves whenever the output register is empty or being drained
  assign en           = !v3_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign lane_dist[0] = in_ch.dist_0;
  assign lane_dist[1] = in_ch.dist_1;
  assign lane_dist[2] = in_ch.dist_2;
  assign lane_dist[3] = in_ch.dist_3;
  assign lane_dist[4] = in_ch.dist_4;

  // one lane per sector
  for (genvar g = 0; g < spw_pkg::NUM_SECTORS; g++) begin : g_lane
    spw_lane u_lane (
      .clk       (clk),
      .en        (en),
      .sect_dist (lane_dist[g]),
      .scfg      (spw_pkg::sector_cfg_t'(sector_word_r[g])),
      .prod      (prod[g])
    );
  end

  // merge the lanes, add bias, tanh per wheel
  spw_merge u_merge (
    .clk      (clk),
    .en       (en),
    .prod     (prod),
    .bias     (bias_r),
    .th_right (th_right),
    .th_left  (th_left)
  );

  // scale into the output register
  spw_scale u_scale_right (
    .clk       (clk),
    .en        (en),
    .th        (th_right),
    .max_speed (max_speed_r),
    .speed     (out_ch.right_speed)
  );

  spw_scale u_scale_left (
    .clk       (clk),
    .en        (en),
    .th        (th_left),
    .max_speed (max_speed_r),
    .speed     (out_ch.left_speed)
  );

  // an accepted word enters the lane stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted word did not enter the lane stage");

  // a stalled pipe keeps every word in flight
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v1_r, v2_r, v3_r}))
    else $error("pipe moved while stalled");

  // a drained output with nothing behind it goes empty
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && out_ch.ready && !v2_r |=> !out_ch.valid)
    else $error("output word repeated");

endmodule
